[rtl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

   // default ring size
   localparam int DEQ_DEPTH = 16;

   // field widths
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

[rtl/double_ended_queue_core.sv]
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit values held in a ring memory.
// Request channel: req_kind and req_value are taken at a rising edge where
// start is high and busy is low. Kinds: push front, push rear, pop front,
// pop rear, dump; other kind codes are dropped without a response.
// Response channel: rsp_valid marks one cycle holding rsp_status,
// rsp_value_res and rsp_last; the receiver cannot stall, so every response
// is taken in the cycle it is shown.
// The first response of a request appears in the cycle after it is taken
// (registered outputs, synchronous memory read).
// Pushes and pops may follow each other every cycle while busy is low; a dump
// of n entries streams n responses back to back, one memory read per cycle,
// with busy high until its last response is shown.
// A push to a full ring answers full; a pop or dump of an empty ring answers
// empty. Reset (synchronous) empties the ring and clears head and count;
// memory contents are left as they are; unwritten data is never returned.
module double_ended_queue_core
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_value_res,
   output logic                      rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   // ring index plus offset, offset below DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(idx) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          wr_addr;
   logic                      wr_en;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          dump_pos_ff, dump_pos_in;
   logic [CNT_W-1:0]          dump_left_ff, dump_left_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic                      rsp_mem_ff, rsp_mem_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      is_full;
   logic                      is_empty;
   logic [IDX_W-1:0]          head_inc;
   logic [IDX_W-1:0]          head_dec;
   logic [IDX_W-1:0]          rear_wr;
   logic [IDX_W-1:0]          rear_rd;
   logic [IDX_W-1:0]          dump_inc;

   // ring positions
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign head_inc = ring_add(head_ff, CNT_W'(1));
   assign head_dec = ring_add(head_ff, CNT_W'(DEPTH - 1));
   assign rear_wr  = ring_add(head_ff, count_ff);
   assign rear_rd  = ring_add(head_ff, count_ff - CNT_W'(1));
   assign dump_inc = ring_add(dump_pos_ff, CNT_W'(1));

   // request decode and next state
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      dump_pos_in   = dump_pos_ff;
      dump_left_in  = dump_left_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_mem_in    = 1'b0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = rear_wr;
      rd_addr       = head_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (req_kind == KIND_PUSH_FRONT) begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_REAR: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_mem_in = 1'b1;
                        count_in   = count_ff - CNT_W'(1);
                        if (req_kind == KIND_POP_FRONT) begin
                           rd_addr = head_ff;
                           head_in = head_inc;
                        end else begin
                           rd_addr = rear_rd;
                        end
                     end
                  end
                  KIND_DUMP: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_mem_in   = 1'b1;
                        rd_addr      = head_ff;
                        rsp_last_in  = (count_ff == CNT_W'(1));
                        dump_pos_in  = head_inc;
                        dump_left_in = count_ff - CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            rsp_valid_in = 1'b1;
            rsp_mem_in   = 1'b1;
            rd_addr      = dump_pos_ff;
            rsp_last_in  = (dump_left_ff == CNT_W'(1));
            dump_pos_in  = dump_inc;
            dump_left_in = dump_left_ff - CNT_W'(1);
            if (dump_left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ring memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_mem_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mem_ff   <= rsp_mem_in;
      end
      dump_pos_ff   <= dump_pos_in;
      dump_left_ff  <= dump_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // outputs
   assign busy          = (state_ff == ST_DUMP);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_res = rsp_mem_ff ? rd_data_ff : '0;
   assign rsp_last      = rsp_last_ff;

endmodule

[rtl/deq_checker.sv]
`timescale 1ns / 1ps

module deq_port_props
   import deq_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [KIND_W-1:0]         req_kind,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      rsp_valid,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic signed [VALUE_W-1:0] rsp_value_res,
   input logic                      rsp_last
);

   // every known request taken while not busy answers in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_PUSH_FRONT || req_kind == KIND_PUSH_REAR ||
       req_kind == KIND_POP_FRONT || req_kind == KIND_POP_REAR || req_kind == KIND_DUMP))
      |=> rsp_valid)
      else $error("request not answered in the next cycle");

   // empty or full answers carry zero data and close the request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_value_res == '0 && rsp_last))
      else $error("refused request with data or without last");

   // while busy a dump stream is in flight and not yet finished
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (rsp_valid && !rsp_last && rsp_status == STATUS_OK))
      else $error("busy without an open dump stream");

   // a dump stream has no gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap in dump stream");

endmodule

bind double_ended_queue_core deq_port_props u_deq_port_props (.*);
